// ===== rtl/mep_pkg.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Widths, modulus constants, controller states, command and status types,
// and the small modular fold shared by the datapath and the multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

    // Word widths.
    localparam int BASE_W = 63;
    localparam int EXP_W  = 63;
    localparam int RES_W  = 30;

    // Modulus and the modulus of the exponent.
    localparam logic [RES_W-1:0] PRIME    = 30'd1000000007;
    localparam logic [RES_W-1:0] PRIME_M1 = 30'd1000000006;

    // Barrett constant, floor(2^60 / PRIME).
    localparam logic [RES_W:0] BARRETT_MU = 31'd1152921496;

    // Radix-4 input reduction: the input word padded to 64 bits.
    localparam int DIGIT_STEPS = (BASE_W + 1) / 2;

    // Exponent bits walked by square-and-multiply.
    localparam int EXP_BITS = 30;

    // Issue period of one exponent bit; equals the multiplier latency.
    localparam int BIT_PERIOD = 5;

    localparam int CNT_W   = 5;
    localparam int PHASE_W = 3;

    // Issue slots inside one exponent bit.
    localparam logic [PHASE_W-1:0] PH_SQUARE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MULTIPLY = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LAST     = PHASE_W'(BIT_PERIOD - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_POWER,
        S_DRAIN,
        S_DONE
    } t_state;

    // Destination of a multiplier result.
    typedef enum logic {
        TAG_SQ,
        TAG_ACC
    } t_tag;

    typedef struct packed {
        logic load;
        logic red_step;
        logic issue_sq;
        logic issue_mul;
        logic exp_shift;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_bit;
    } t_dp_sts;

    // Reduces v modulo m, given that v is below 4 * m.
    function automatic logic [RES_W-1:0] mep_mod4(input logic [RES_W+1:0] v,
                                                  input logic [RES_W-1:0] m);
        logic [RES_W+2:0] m1;
        logic [RES_W+2:0] m2;
        logic [RES_W+2:0] m3;
        logic [RES_W+2:0] d1;
        logic [RES_W+2:0] d2;
        logic [RES_W+2:0] d3;
        logic [RES_W-1:0] res;
        m1 = {3'b000, m};
        m2 = {2'b00, m, 1'b0};
        m3 = m1 + m2;
        d1 = {1'b0, v} - m1;
        d2 = {1'b0, v} - m2;
        d3 = {1'b0, v} - m3;
        if (!d3[RES_W+2]) begin
            res = d3[RES_W-1:0];
        end else if (!d2[RES_W+2]) begin
            res = d2[RES_W-1:0];
        end else if (!d1[RES_W+2]) begin
            res = d1[RES_W-1:0];
        end else begin
            res = v[RES_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/modular_exponentiation_prime.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation modulo 1000000007
// Returns base to the power exponent modulo the prime, one result word for
// each input word, by right-to-left square-and-multiply.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  input    in         i_valid / o_stall  i_base (63 b), i_exponent (63 b)
//  output   out        o_valid / i_stall  o_power_result (30 b)
//
// The block works on one input word at a time: the next word can be
// accepted from the cycle in which the result of the last is shown. The
// block first reduces the base modulo the prime and the exponent modulo the
// prime minus one, two bits a cycle; then it walks the 30 exponent bits on
// the one shared Barrett multiplier, which takes the square of a bit in its
// first issue slot and the optional multiply in its second. A drain state
// waits for the multiplier, and then the result is loaded.
// Reset is synchronous and clears the controller and the multiplier's valid
// pipeline. A stalled result word sits in its own register while the next
// input word is accepted.
//
`default_nettype none

module modular_exponentiation_prime
    import mep_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [BASE_W-1:0] i_base,
    input  wire logic [EXP_W-1:0]  i_exponent,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [RES_W-1:0]       o_power_result
);

    // Commands from the controller, status back from the datapath.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller owns the handshake; it loads a word only when the
    // stage part of the datapath has been idle, so operands held on the
    // input port are sampled exactly once, at the accepting edge.
    mep_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // The datapath holds the reduced base as the running square, the
    // reduced exponent as a right shifter and the accumulator; the result
    // register is loaded from the accumulator once the walk is done.
    mep_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .o_power_result (o_power_result)
    );

endmodule

`default_nettype wire

// ===== rtl/mep_mulmod.sv =====
// ---------------------------------------------------------------------------
// Pipelined modular multiplier
// Barrett multiplier modulo the prime, one operation per cycle,
// with a tag that routes each result back to its register.
// ---------------------------------------------------------------------------
`default_nettype none

module mep_mulmod
    import mep_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_tag             i_tag,
    input  wire logic [RES_W-1:0] i_a,
    input  wire logic [RES_W-1:0] i_b,
    output logic                  o_valid,
    output t_tag                  o_tag,
    output logic [RES_W-1:0]      o_res
);

    logic [3:0]           r_vld;
    t_tag                 r_tag [4];
    logic [2*RES_W-1:0]   r_prod;
    logic [RES_W:0]       r_q;
    logic [RES_W+1:0]     r_lo2;
    logic [RES_W+1:0]     r_lo3;
    logic [RES_W+1:0]     r_qp;
    logic [RES_W+1:0]     r_rem;

    logic [2*RES_W-1:0]   w_prod;
    logic [2*RES_W+1:0]   w_qfull;
    logic [2*RES_W:0]     w_qp;

    assign w_prod  = i_a * i_b;
    assign w_qfull = r_prod[2*RES_W-1:RES_W-1] * BARRETT_MU;
    assign w_qp    = r_q * PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
        r_tag[3] <= r_tag[2];
        r_prod   <= w_prod;
        r_q      <= w_qfull[2*RES_W+1:RES_W+1];
        r_lo2    <= r_prod[RES_W+1:0];
        r_qp     <= w_qp[RES_W+1:0];
        r_lo3    <= r_lo2;
        // The true remainder is below 3 * PRIME, so the low bits suffice.
        r_rem    <= r_lo3 - r_qp;
    end

    assign o_valid = r_vld[3];
    assign o_tag   = r_tag[3];
    assign o_res   = mep_mod4(r_rem, PRIME);

endmodule

`default_nettype wire

// ===== rtl/mep_dp.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation datapath
// Input reduction, square and accumulator registers, exponent shifter,
// the shared modular multiplier and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mep_dp
    import mep_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    input  wire logic [BASE_W-1:0] i_base,
    input  wire logic [EXP_W-1:0] i_exponent,
    output logic [RES_W-1:0]      o_power_result
);

    logic [BASE_W:0]    r_base_sh;
    logic [EXP_W:0]     r_exp_sh;
    logic [RES_W-1:0]   r_sq;
    logic [RES_W-1:0]   r_acc;
    logic [RES_W-1:0]   r_exp;
    logic [RES_W-1:0]   r_out;

    logic               mm_in_valid;
    t_tag               mm_in_tag;
    logic [RES_W-1:0]   mm_in_a;
    logic               mm_valid;
    t_tag               mm_tag;
    logic [RES_W-1:0]   mm_res;

    assign mm_in_valid = i_cmd.issue_sq | i_cmd.issue_mul;
    assign mm_in_tag   = i_cmd.issue_mul ? TAG_ACC : TAG_SQ;
    assign mm_in_a     = i_cmd.issue_mul ? r_acc : r_sq;

    mep_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mm_in_valid),
        .i_tag   (mm_in_tag),
        .i_a     (mm_in_a),
        .i_b     (r_sq),
        .o_valid (mm_valid),
        .o_tag   (mm_tag),
        .o_res   (mm_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base_sh <= {1'b0, i_base};
            r_exp_sh  <= {1'b0, i_exponent};
        end else if (i_cmd.red_step) begin
            r_base_sh <= {r_base_sh[BASE_W-2:0], 2'b00};
            r_exp_sh  <= {r_exp_sh[EXP_W-2:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq <= '0;
        end else if (i_cmd.red_step) begin
            r_sq <= mep_mod4({r_sq, r_base_sh[BASE_W:BASE_W-1]}, PRIME);
        end else if (mm_valid && mm_tag == TAG_SQ) begin
            r_sq <= mm_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= RES_W'(1);
        end else if (mm_valid && mm_tag == TAG_ACC) begin
            r_acc <= mm_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_exp <= '0;
        end else if (i_cmd.red_step) begin
            r_exp <= mep_mod4({r_exp, r_exp_sh[EXP_W:EXP_W-1]}, PRIME_M1);
        end else if (i_cmd.exp_shift) begin
            r_exp <= {1'b0, r_exp[RES_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    assign o_sts.exp_bit  = r_exp[0];
    assign o_power_result = r_out;

endmodule

`default_nettype wire

// ===== rtl/mep_ctrl.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences input reduction, the square-and-multiply walk over the exponent
// bits and the hand-over of the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module mep_ctrl
    import mep_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [PHASE_W-1:0]   r_phase;
    logic [PHASE_W-1:0]   n_phase;
    logic                 r_out_valid;
    logic                 n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.red_step = 1'b1;
                if (r_cnt == CNT_W'(DIGIT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_phase = PH_SQUARE;
                    n_state = S_POWER;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_POWER: begin
                if (r_phase == PH_SQUARE) begin
                    o_cmd.issue_sq = 1'b1;
                end
                if (r_phase == PH_MULTIPLY) begin
                    o_cmd.issue_mul = i_sts.exp_bit;
                    o_cmd.exp_shift = 1'b1;
                end
                if (r_phase == PH_LAST) begin
                    n_phase = PH_SQUARE;
                    if (r_cnt == CNT_W'(EXP_BITS - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            S_DRAIN: begin
                // The last multiply lands in the accumulator at this edge.
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid & i_stall;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/mep_chk.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the top-level ports for busy behaviour, result range and the hold of a stalled result.
// ---------------------------------------------------------------------------
`default_nettype none

module mep_chk
    import mep_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_stall,
    input wire logic             o_valid,
    input wire logic             i_stall,
    input wire logic [RES_W-1:0] o_power_result
);

    // An accepted word keeps the block busy for a while.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall ##1 o_stall)
        else $error("block not busy after accepting a word");

    // A result only appears as the busy period ends.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result word appeared without a busy period");

    // Every result is a residue modulo the prime.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_power_result < PRIME))
        else $error("result word not below the modulus");

    // A stalled result word holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_power_result)))
        else $error("stalled result word changed");

endmodule

bind modular_exponentiation_prime mep_chk u_mep_chk (.*);

`default_nettype wire

// ===== tb/sv/modular_exponentiation_prime_tb.sv =====
// ---------------------------------------------------------------------------
// Testbench for modular_exponentiation_prime
// Sends base and exponent words and checks every result word against a
// square-and-multiply predictor modulo 1000000007. Directed corner values
// come first, then random words under several idling patterns and one long
// receiver hold-off that backs the block up into its input.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_prime_tb;
    import mep_pkg::*;

    // The run is bounded well above the slowest correct run. About 560 words,
    // plus stalls and the hold-off, stay far below this figure.
    localparam int CYCLE_LIMIT  = 1000000;
    // The tail wait covers the processing time of one full word.
    localparam int TAIL_CYCLES  = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_WORDS = 130;
    localparam int BURST_WORDS  = 24;

    localparam logic [63:0] MOD64    = 64'(PRIME);
    localparam logic [63:0] MOD_M164 = 64'(PRIME_M1);
    localparam logic [62:0] TOP63    = 63'h7FFF_FFFF_FFFF_FFFF;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [BASE_W-1:0] i_base;
    logic [EXP_W-1:0]  i_exponent;
    logic              o_valid;
    logic              i_stall;
    logic [RES_W-1:0]  o_power_result;

    // Expected result words, oldest at the front.
    logic [RES_W-1:0] expected_powers[$];

    int error_count     = 0;
    int words_sent      = 0;
    int results_checked = 0;

    // Idling pattern, in cycles of a hundred. Both are changed only just
    // after a rising edge, so that the falling-edge processes see a settled
    // value.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // The test sequence raises hold_requests; the receiver process serves
    // each request with a long stall that it counts itself.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    modular_exponentiation_prime dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_base         (i_base),
        .i_exponent     (i_exponent),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_power_result (o_power_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a run that has not finished by now has hung.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("modular_exponentiation_prime: mismatch");
        $finish;
    end

    // Square-and-multiply predictor. The base is reduced modulo the prime
    // and the exponent modulo the prime minus one before the bit walk, so an
    // exponent that is a nonzero multiple of the prime minus one gives 1
    // even for a base that is a multiple of the prime. Every product of two
    // residues stays below 2^60 and fits the 64-bit arithmetic.
    function automatic logic [RES_W-1:0] expected_power(input logic [BASE_W-1:0] b,
                                                        input logic [EXP_W-1:0]  e);
        logic [63:0] square;
        logic [63:0] acc;
        logic [63:0] ex;
        square = {1'b0, b} % MOD64;
        ex     = {1'b0, e} % MOD_M164;
        acc    = 64'd1;
        for (int k = 0; k < EXP_BITS; k++) begin
            if (ex[k]) begin
                acc = (acc * square) % MOD64;
            end
            square = (square * square) % MOD64;
        end
        return acc[RES_W-1:0];
    endfunction

    // Receiver: stalls at random at the current rate, or for a whole
    // hold-off stretch once one has been requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            i_stall     <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= hold_served + 1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Result checker: every accepted result word is compared with the
    // oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_powers.size() == 0) begin
                $error("power_result: no word expected, got %0d", o_power_result);
                error_count++;
            end else begin
                if (o_power_result !== expected_powers[0]) begin
                    $error("power_result: expected %0d, got %0d",
                           expected_powers[0], o_power_result);
                    error_count++;
                end
                void'(expected_powers.pop_front());
                results_checked++;
            end
        end
    end

    // Offers one word, after a random gap at the current idle rate, and
    // holds it until the block accepts it. Entered and left at a falling
    // edge, so the valid line gets exactly one assignment per edge.
    task automatic send_word(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_base     <= b;
        i_exponent <= e;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        expected_powers.insert(expected_powers.size(), expected_power(b, e));
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every expected result word has arrived.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_powers.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        @(negedge i_clk);
    endtask

    // Bases: a mix of full-width noise, small values, multiples of the prime
    // and their neighbours, residues, and values close to the top of the
    // field.
    function automatic logic [BASE_W-1:0] random_base();
        logic [63:0] v;
        case ($urandom_range(7))
            0, 1: v = {$urandom, $urandom};
            2:    v = 64'($urandom_range(20));
            3:    v = 64'($urandom) * MOD64;
            4:    v = 64'($urandom) * MOD64 + 64'($urandom_range(5)) - 64'd2;
            5:    v = 64'(TOP63) - 64'($urandom_range(100));
            default: v = 64'($urandom_range(PRIME - 1));
        endcase
        return v[BASE_W-1:0];
    endfunction

    // Exponents: noise, zero and small values, 30-bit values, values near the top,
    // and multiples of the prime minus one with and without a small offset.
    function automatic logic [EXP_W-1:0] random_exponent();
        logic [63:0] v;
        case ($urandom_range(8))
            0, 1: v = {$urandom, $urandom};
            2:    v = 64'($urandom_range(3));
            3:    v = 64'($urandom_range(40));
            4:    v = 64'($urandom) * MOD_M164;
            5:    v = 64'($urandom) * MOD_M164 + 64'($urandom_range(4));
            6:    v = 64'(TOP63) - 64'($urandom_range(100));
            default: v = 64'($urandom) & 64'h3FFF_FFFF;
        endcase
        return v[EXP_W-1:0];
    endfunction

    task automatic send_random_words(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(random_base(), random_exponent());
        end
    endtask

    // Field extremes and the special cases: a zero exponent and an exponent
    // that is a multiple of the prime minus one, each also with a base that
    // is a multiple of the prime, and bits of the exponent above 30.
    task automatic test_corner_values();
        set_idling(0, 0);
        send_word('0, '0);
        send_word('0, 63'd1);
        send_word('0, TOP63);
        send_word(TOP63, '0);
        send_word(TOP63, TOP63);
        send_word(63'd1, TOP63);
        send_word(63'(PRIME), '0);
        send_word(63'(PRIME), 63'd1);
        send_word(63'(PRIME), 63'(PRIME_M1));
        send_word(63'(MOD64 * 64'd2), 63'(MOD_M164 * 64'd3));
        send_word(63'(PRIME_M1), 63'd2);
        send_word(63'd2, 63'(PRIME_M1));
        send_word(63'd2, 63'(PRIME_M1) - 63'd1);
        send_word(63'd2, 63'h3FFF_FFFF);
        send_word(63'd3, 63'h2000_0000);
        send_word(63'(MOD64 + 64'd2), 63'(PRIME));
        send_word(63'(PRIME) - 63'd1, TOP63 - 63'd1);
        send_word(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
        send_word(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
        drain_results();
    endtask

    task automatic test_random_steady();
        set_idling(0, 0);
        send_random_words(RANDOM_WORDS);
        drain_results();
    endtask

    task automatic test_random_sender_gaps();
        set_idling(49, 0);
        send_random_words(RANDOM_WORDS);
        drain_results();
    endtask

    task automatic test_random_receiver_stalls();
        set_idling(0, 49);
        send_random_words(RANDOM_WORDS);
        drain_results();
    endtask

    task automatic test_random_both_idle();
        set_idling(35, 35);
        send_random_words(RANDOM_WORDS);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the result register and the datapath both fill and the input stalls.
    task automatic test_backpressure();
        set_idling(0, 0);
        @(posedge i_clk);
        hold_requests = hold_requests + 1;
        @(negedge i_clk);
        send_random_words(BURST_WORDS);
        drain_results();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_base     = '0;
        i_exponent = '0;
        i_stall    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_corner_values();
        test_random_steady();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();
        test_backpressure();

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered corner values, random words under four idling patterns %s",
                 "and a long hold-off.");
        $display("%0d words sent, %0d result words checked, %0d errors.",
                 words_sent, results_checked, error_count);
        if (error_count == 0 && expected_powers.size() == 0) begin
            $display("modular_exponentiation_prime: match");
        end else begin
            $display("modular_exponentiation_prime: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
